FILE: hw/rtl/wslm_pkg.sv
package wslm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int SW = 24;
    localparam int AXES = 6;
    localparam int NOISE_W = 29;
    localparam int COUNT_W = 16;
    localparam int LIMIT_W = 23;
    localparam int DIFF_W = 30;
    localparam int SQ_W = 62;
    localparam int ROOT_W = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [DIFF_W-1:0] DIFF_CLAMP = 30'h2000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BASE = 3'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DEAD = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    typedef struct packed {
        logic signed [SW-1:0] force_x;
        logic signed [SW-1:0] force_y;
        logic signed [SW-1:0] force_z;
        logic signed [SW-1:0] torque_x;
        logic signed [SW-1:0] torque_y;
        logic signed [SW-1:0] torque_z;
    } sample_t;

    typedef struct packed {
        logic [1:0] status;
        logic signed [SW-1:0] out_force_x;
        logic signed [SW-1:0] out_force_y;
        logic signed [SW-1:0] out_force_z;
        logic signed [SW-1:0] out_torque_x;
        logic signed [SW-1:0] out_torque_y;
        logic signed [SW-1:0] out_torque_z;
    } result_t;

    // front to back job: squared sums, over-limit flag, echo
    typedef struct packed {
        logic [SQ_W-1:0] force_sq;
        logic [SQ_W-1:0] torque_sq;
        logic            over;
        sample_t         smp;
    } job_t;

endpackage

FILE: hw/rtl/wrench_stall_and_limit_monitor.sv
// Wrench stall and limit monitor.
// Input channel s_valid/s_ready/s_data carries one six-axis sample
// (signed, 8 fractional bits). Output channel m_valid/m_ready/m_data
// returns one result per sample: status (ok, dead stream, over limit)
// and the sample echoed.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes register
// cfg_index; indexes past the last register are dropped. Write only idle.
// The front stage computes one axis difference square per cycle; a
// two-entry queue feeds the back stage, whose shared bit-pair square
// root computes two norms per sample. The front stage can take a new
// sample while the back stage still works on earlier ones; the square
// root unit is the slowest step.
// Reset (aresetn low, synchronous) clears the previous sample and the
// unchanged counter and loads register defaults.
// A stalled receiver holds the result; the queue then fills and
// s_ready drops until results drain.
module wrench_stall_and_limit_monitor (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wslm_pkg::sample_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wslm_pkg::result_t    m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [wslm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wslm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wslm_pkg::*;

    logic [NOISE_W-1:0] noise_reg;
    logic [COUNT_W-1:0] stall_reg;
    logic [AXES*LIMIT_W-1:0] limits_reg;
    logic fj_valid, fj_ready, bj_valid, bj_ready;
    job_t fjob, bjob;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg <= '0;
            stall_reg <= '1;
            limits_reg <= '1;
        end else if (cfg_valid) begin
            if (cfg_index == REG_NOISE) noise_reg <= cfg_data[NOISE_W-1:0];
            else if (cfg_index == REG_STALL) stall_reg <= cfg_data[COUNT_W-1:0];
            else limits_reg[(cfg_index - REG_LIMIT_BASE)*LIMIT_W +: LIMIT_W]
                <= cfg_data[LIMIT_W-1:0];
        end
    end

    wslm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .limits(limits_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
    );

    wslm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fjob),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bjob)
    );

    wslm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
        .noise_limit(noise_reg), .stall_limit(stall_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

FILE: hw/rtl/wslm_front.sv
module wslm_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  wslm_pkg::sample_t       s_data,
    input  logic [wslm_pkg::AXES*wslm_pkg::LIMIT_W-1:0] limits,
    output logic                    job_valid,
    input  logic                    job_ready,
    output wslm_pkg::job_t          job
);
    import wslm_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_SEND} fstate_t;

    fstate_t state_reg;
    logic [SW-1:0] prev_reg [AXES];
    logic [SW-1:0] cur_reg [AXES];
    logic [2:0] axis_reg;
    logic [SQ_W-1:0] fsq_reg, tsq_reg;
    logic over_reg;
    sample_t smp_reg;

    logic signed [SW:0] diff;
    logic [SW:0] dmag;
    logic [DIFF_W-1:0] dcl;
    logic [SQ_W-1:0] sq;
    logic [SW-1:0] cmag;
    logic [LIMIT_W-1:0] lim;

    always_comb begin
        diff = $signed({cur_reg[axis_reg][SW-1], cur_reg[axis_reg]})
             - $signed({prev_reg[axis_reg][SW-1], prev_reg[axis_reg]});
        dmag = diff[SW] ? SW'(0) - diff : diff;
        dcl = (DIFF_W'(dmag) > DIFF_CLAMP) ? DIFF_CLAMP : DIFF_W'(dmag);
        sq = SQ_W'(dcl) * SQ_W'(dcl);
        cmag = cur_reg[axis_reg][SW-1] ? SW'(0) - cur_reg[axis_reg] : cur_reg[axis_reg];
        lim = limits[axis_reg*LIMIT_W +: LIMIT_W];
    end

    assign s_ready = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_SEND);
    assign job = '{force_sq: fsq_reg, torque_sq: tsq_reg, over: over_reg, smp: smp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            for (int i = 0; i < AXES; i++) prev_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: if (s_valid) begin
                    cur_reg[0] <= s_data.force_x;
                    cur_reg[1] <= s_data.force_y;
                    cur_reg[2] <= s_data.force_z;
                    cur_reg[3] <= s_data.torque_x;
                    cur_reg[4] <= s_data.torque_y;
                    cur_reg[5] <= s_data.torque_z;
                    smp_reg <= s_data;
                    axis_reg <= '0;
                    fsq_reg <= '0;
                    tsq_reg <= '0;
                    over_reg <= 1'b0;
                    state_reg <= F_SQ;
                end
                F_SQ: begin
                    if (axis_reg < 3'd3) fsq_reg <= fsq_reg + sq;
                    else tsq_reg <= tsq_reg + sq;
                    if ((cmag[SW-1]) || (SW'(lim) < cmag)) over_reg <= 1'b1;
                    prev_reg[axis_reg] <= cur_reg[axis_reg];
                    if (axis_reg == 3'(AXES-1)) state_reg <= F_SEND;
                    axis_reg <= axis_reg + 3'd1;
                end
                F_SEND: if (job_ready) state_reg <= F_IDLE;
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/wslm_queue.sv
module wslm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  wslm_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output wslm_pkg::job_t out_job
);
    import wslm_pkg::*;

    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_job;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (out_valid && out_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !in_ready) else $error("full queue ready");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !in_valid) |=> !out_valid) else $error("empty queue valid");
endmodule

FILE: hw/rtl/wslm_back.sv
module wslm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  wslm_pkg::job_t                 job,
    input  logic [wslm_pkg::NOISE_W-1:0]   noise_limit,
    input  logic [wslm_pkg::COUNT_W-1:0]   stall_limit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wslm_pkg::result_t              m_data
);
    import wslm_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_ROOT, B_MUL, B_DECIDE, B_OUT} bstate_t;

    bstate_t state_reg;
    job_t job_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] root_reg;
    logic [SQ_W-1:0] bit_reg;
    logic sel_reg;
    logic [ROOT_W-1:0] fnorm_reg, tnorm_reg;
    logic [ROOT_W+4:0] change_reg;
    logic [COUNT_W-1:0] count_reg;
    result_t out_reg;

    logic [SQ_W:0] trial;
    logic [COUNT_W-1:0] cnt_inc;
    logic [1:0] st;

    always_comb begin
        trial = {1'b0, rem_reg} - ({1'b0, root_reg} + {1'b0, bit_reg});
        cnt_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        st = ST_OK;
        if (change_reg <= (ROOT_W+5)'(noise_limit)) begin
            if (cnt_inc >= stall_limit) st = ST_DEAD;
        end
        if (st == ST_OK && job_reg.over) st = ST_OVER;
    end

    assign job_ready = (state_reg == B_IDLE);
    assign m_valid = (state_reg == B_OUT);
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                B_IDLE: if (job_valid) begin
                    job_reg <= job;
                    rem_reg <= job.force_sq;
                    root_reg <= '0;
                    bit_reg <= SQ_W'(1) << (SQ_W-2);
                    sel_reg <= 1'b0;
                    state_reg <= B_ROOT;
                end
                B_ROOT: begin
                    if (bit_reg[0] && !sel_reg) begin
                        fnorm_reg <= !trial[SQ_W]
                            ? ROOT_W'((root_reg >> 1) + 1'b1) : ROOT_W'(root_reg >> 1);
                        rem_reg <= job_reg.torque_sq;
                        root_reg <= '0;
                        bit_reg <= SQ_W'(1) << (SQ_W-2);
                        sel_reg <= 1'b1;
                    end else begin
                        if (!trial[SQ_W]) begin
                            rem_reg <= trial[SQ_W-1:0];
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end else begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                        if (bit_reg[0]) begin
                            tnorm_reg <= !trial[SQ_W]
                                ? ROOT_W'((root_reg >> 1) + 1'b1) : ROOT_W'(root_reg >> 1);
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    change_reg <= (ROOT_W+5)'(fnorm_reg)
                                + ((ROOT_W+5)'(tnorm_reg) << 3) + ((ROOT_W+5)'(tnorm_reg) << 1);
                    state_reg <= B_DECIDE;
                end
                B_DECIDE: begin
                    count_reg <= (change_reg > (ROOT_W+5)'(noise_limit)) ? '0 : cnt_inc;
                    out_reg <= '{status: st,
                                 out_force_x: job_reg.smp.force_x,
                                 out_force_y: job_reg.smp.force_y,
                                 out_force_z: job_reg.smp.force_z,
                                 out_torque_x: job_reg.smp.torque_x,
                                 out_torque_y: job_reg.smp.torque_y,
                                 out_torque_z: job_reg.smp.torque_z};
                    state_reg <= B_OUT;
                end
                B_OUT: if (m_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != 2'd3)) else $error("bad status");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROOT) |=> (state_reg == B_ROOT || state_reg == B_MUL))
        else $error("root exit");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DECIDE && change_reg > (ROOT_W+5)'(noise_limit)) |=> count_reg == '0)
        else $error("count not cleared");
endmodule

FILE: dv/wrench_stall_and_limit_monitor_tb.sv
`timescale 1ns / 1ps

module wrench_stall_and_limit_monitor_tb;
    import wslm_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 700;

    class wrench_scoreboard;
        logic [NOISE_W-1:0] noise_limit;
        logic [COUNT_W-1:0] stall_limit;
        logic [LIMIT_W-1:0] axis_limit[AXES];
        logic signed [SW-1:0] prev_axis[AXES];
        logic [COUNT_W-1:0] unchanged_count;
        result_t pending_results[$];
        int errors;
        int checked;
        int n_dead;
        int n_over;

        function void reset_state();
            noise_limit = '0;
            stall_limit = '1;
            foreach (axis_limit[i]) axis_limit[i] = '1;
            foreach (prev_axis[i]) prev_axis[i] = '0;
            unchanged_count = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NOISE) noise_limit = val[NOISE_W-1:0];
            else if (idx == REG_STALL) stall_limit = val[COUNT_W-1:0];
            else axis_limit[idx - REG_LIMIT_BASE] = val[LIMIT_W-1:0];
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v = v - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        function longint unsigned group_norm(logic signed [SW-1:0] cur[AXES], int first);
            longint unsigned acc;
            longint d;
            acc = 0;
            for (int i = first; i < first + 3; i++) begin
                d = longint'(cur[i]) - longint'(prev_axis[i]);
                if (d < 0) d = -d;
                if (d > (64'd1 << 29)) d = 64'd1 << 29;
                acc += longint'(d) * longint'(d);
            end
            return int_sqrt(acc);
        endfunction

        function void note_sample(sample_t s);
            logic signed [SW-1:0] cur[AXES];
            longint unsigned change;
            longint mag;
            result_t r;
            cur = '{s.force_x, s.force_y, s.force_z, s.torque_x, s.torque_y, s.torque_z};
            change = group_norm(cur, 0) + 10 * group_norm(cur, 3);
            foreach (cur[i]) prev_axis[i] = cur[i];
            r.status = ST_OK;
            if (change > noise_limit) begin
                unchanged_count = '0;
            end else begin
                if (unchanged_count != COUNT_MAX) unchanged_count++;
                if (unchanged_count >= stall_limit) r.status = ST_DEAD;
            end
            if (r.status == ST_OK) begin
                foreach (cur[i]) begin
                    mag = longint'(cur[i]);
                    if (mag < 0) mag = -mag;
                    if (mag > longint'(axis_limit[i])) r.status = ST_OVER;
                end
            end
            if (r.status == ST_DEAD) n_dead++;
            if (r.status == ST_OVER) n_over++;
            r.out_force_x = s.force_x;
            r.out_force_y = s.force_y;
            r.out_force_z = s.force_z;
            r.out_torque_x = s.torque_x;
            r.out_torque_y = s.torque_y;
            r.out_torque_z = s.torque_z;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            logic [SW-1:0] g[AXES];
            logic [SW-1:0] w[AXES];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            g = '{got.out_force_x, got.out_force_y, got.out_force_z,
                  got.out_torque_x, got.out_torque_y, got.out_torque_z};
            w = '{want.out_force_x, want.out_force_y, want.out_force_z,
                  want.out_torque_x, want.out_torque_y, want.out_torque_z};
            foreach (g[i]) if (g[i] !== w[i]) begin
                $display("%0t: axis %0d expected %h actual %h", $time, i, w[i], g[i]);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sample_t s_data;
    logic m_valid;
    logic m_ready;
    result_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wrench_stall_and_limit_monitor dut (.*);

    wrench_scoreboard sb = new();
    bit hold_req;
    bit no_idle;
    int idle_cycles;
    int n_items;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_sample(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("wrench_stall_and_limit_monitor verification failed");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold on request
    initial begin
        int hold;
        hold = 0;
        m_ready <= 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold == 0) begin
                hold = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] lim);
        for (int i = 0; i < AXES; i++) write_reg(REG_LIMIT_BASE + CFG_IDX_W'(i), 32'(lim));
    endtask

    // valid stays up after a transfer; the next call may drop it, drain() drops it
    task automatic send_sample(sample_t s);
        while (!no_idle && $urandom_range(0, 99) < 10) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic sample_t uniform_sample(int unsigned span);
        sample_t s;
        logic signed [SW-1:0] v[AXES];
        foreach (v[i])
            v[i] = (span == 0) ? SW'($urandom) : SW'(int'($urandom_range(0, 2 * span)) - int'(span));
        s = {v[0], v[1], v[2], v[3], v[4], v[5]};
        return s;
    endfunction

    function automatic sample_t nudge(sample_t s, int unsigned step);
        logic signed [SW-1:0] v[AXES];
        v = '{s.force_x, s.force_y, s.force_z, s.torque_x, s.torque_y, s.torque_z};
        foreach (v[i]) v[i] = v[i] + SW'(int'($urandom_range(0, 2 * step)) - int'(step));
        return {v[0], v[1], v[2], v[3], v[4], v[5]};
    endfunction

    // mostly drifting streams with small noise and stalls, some big jumps
    task automatic random_run(int count, int unsigned step);
        sample_t cur;
        cur = uniform_sample(0);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: cur = uniform_sample(0);
                1: cur = uniform_sample(4096);
                2, 3, 4: ;
                default: cur = nudge(cur, step);
            endcase
            send_sample(cur);
        end
    endtask

    initial begin
        sample_t mx, mn, z;
        aresetn <= 0;
        s_valid <= 0;
        s_data <= '0;
        cfg_valid <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        hold_req = 0;
        no_idle = 0;
        n_items = 0;
        idle_cycles = 0;
        sb.reset_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        mx = {AXES{24'sh7FFFFF}};
        mn = {AXES{24'sh800000}};
        z = '0;
        send_sample(z);
        send_sample(z);
        send_sample(mx);
        send_sample(mn);
        send_sample(mx);
        for (int i = 0; i < AXES; i++) send_sample(z | (sample_t'(24'h800000) << (SW * i)));
        send_sample({24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000});
        drain();

        write_reg(REG_STALL, 0);
        write_reg(REG_NOISE, 0);
        send_sample(mx);
        send_sample(mx);
        send_sample(z);
        send_sample(z);
        drain();

        write_reg(REG_STALL, 3);
        write_reg(REG_NOISE, 50);
        set_limits(23'd2000);
        for (int k = 0; k < 5; k++) send_sample({24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd2});
        send_sample({24'sd2500, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
        drain();

        write_reg(REG_NOISE, 2000);
        write_reg(REG_STALL, 4);
        for (int i = 0; i < AXES; i++)
            write_reg(REG_LIMIT_BASE + CFG_IDX_W'(i), $urandom_range(0, 8388607));
        random_run(60, 30);
        hold_req = 1;
        random_run(40, 30);
        drain();

        write_reg(REG_NOISE, 29'h1FFFFFFF);
        write_reg(REG_STALL, 16'hFFFF);
        set_limits(0);
        random_run(60, 500);
        drain();

        write_reg(REG_NOISE, 0);
        write_reg(REG_STALL, 1);
        set_limits(23'h7FFFFF);
        no_idle = 1;
        random_run(100, 2);
        no_idle = 0;
        drain();

        write_reg(REG_NOISE, $urandom_range(100, 100000));
        write_reg(REG_STALL, $urandom_range(2, 8));
        for (int i = 0; i < AXES; i++)
            write_reg(REG_LIMIT_BASE + CFG_IDX_W'(i), $urandom_range(0, 300000));
        random_run(160, 2000);

        s_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        $display("Sent %0d samples, checked %0d results (%0d dead stream, %0d over limit)",
                 n_items, sb.checked, sb.n_dead, sb.n_over);
        $display("Settings covered stall limits 0..65535, noise 0..max, axis limits 0..max.");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("wrench_stall_and_limit_monitor verification clean");
        else
            $display("wrench_stall_and_limit_monitor verification failed");
        $finish;
    end
endmodule
